>>> hw/rtl/lzw_encoder_12bit_defines.svh
// assertion macros for the lzw encoder
// used by files that carry concurrent checks; expects clock and reset in scope
`ifndef LZW_ENCODER_12BIT_DEFINES_SVH
`define LZW_ENCODER_12BIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LZW_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("lzw check failed");
`define LZW_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("lzw check failed");
`else
`define LZW_ASSERT(label, expr)
`define LZW_ASSERT_IMPL(label, ante, cons)
`endif
`endif

>>> hw/rtl/lzw_pkg.sv
// shared constants and types of the lzw encoder
// no dependencies
package lzw_pkg;

   localparam int CODE_BITS      = 12;
   localparam int BYTE_BITS      = 8;
   localparam int IDX_BITS       = CODE_BITS + BYTE_BITS;
   localparam int TABLE_DEPTH    = 1 << IDX_BITS;
   localparam int EPOCH_BITS_DEF = 8;
   localparam int OUTQ_DEPTH     = 4;
   localparam int OUTQ_PTR_BITS  = 2;
   localparam int OUTQ_CNT_BITS  = 3;

   localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(256);
   localparam logic [CODE_BITS-1:0] END_CODE   = {CODE_BITS{1'b1}};

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [BYTE_BITS-1:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 last;
   } rsp_type;

   // up to two codes written into the output queue in one cycle
   typedef struct packed {
      logic [1:0] n;
      rsp_type    ent0;
      rsp_type    ent1;
   } push_type;

   typedef struct packed {
      logic                busy;
      logic [IDX_BITS-1:0] addr;
   } clr_stat_type;

endpackage

>>> hw/rtl/lzw_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module lzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lzw_clear.sv
// stream epoch counter and table clearing sweep
// depends on lzw_pkg
module lzw_clear #(
   parameter int EPOCH_BITS = lzw_pkg::EPOCH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  eos,
   output lzw_pkg::clr_stat_type stat,
   output logic [EPOCH_BITS-1:0] epoch
);

   logic                         busy_ff, busy_in;
   logic [lzw_pkg::IDX_BITS-1:0] addr_ff, addr_in;
   logic [EPOCH_BITS-1:0]        epoch_ff, epoch_in;

   always_comb begin
      busy_in  = busy_ff;
      addr_in  = addr_ff;
      epoch_in = epoch_ff;
      if (busy_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == {lzw_pkg::IDX_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end else if (eos) begin
         epoch_in = epoch_ff + 1'b1;
         // epoch wraps: old marks would alias, so sweep the table
         if (epoch_ff == {EPOCH_BITS{1'b1}}) begin
            busy_in = 1'b1;
            addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         addr_ff  <= '0;
         epoch_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         addr_ff  <= addr_in;
         epoch_ff <= epoch_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.addr = addr_ff;
   assign epoch     = epoch_ff;

endmodule

>>> hw/rtl/lzw_outq.sv
// small output queue, up to two pushes and one pop per cycle
// depends on lzw_pkg
module lzw_outq (
   input  logic              clock,
   input  logic              reset,
   input  lzw_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzw_pkg::rsp_type  rsp_data
);

   lzw_pkg::rsp_type                 q_ff [lzw_pkg::OUTQ_DEPTH];
   logic [lzw_pkg::OUTQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lzw_pkg::OUTQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lzw_pkg::OUTQ_CNT_BITS-1:0] count_ff, count_in;
   logic                              pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   // room for a full pair regardless of this cycle's pop
   assign room = (count_ff <= lzw_pkg::OUTQ_CNT_BITS'(lzw_pkg::OUTQ_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.n;
      rd_ptr_in = rd_ptr_ff + {{(lzw_pkg::OUTQ_PTR_BITS-1){1'b0}}, pop};
      count_in  = count_ff + {{(lzw_pkg::OUTQ_CNT_BITS-2){1'b0}}, push.n}
                  - {{(lzw_pkg::OUTQ_CNT_BITS-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.ent0;
      end
      if (push.n == 2'd2) begin
         q_ff[wr_ptr_ff + 1'b1] <= push.ent1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/lzw_encoder_12bit.sv
// lzw encoder, 12-bit codes: each request first reads the child table at
// (prefix, byte), then resolves hit or miss and writes back the new pair
// a read waits until the request ahead has resolved, and a resolve waits for room in
// the output queue; a code goes through s1, the table read and the queue to rsp_valid
// after reset, and after every 2^EPOCH_BITS-th end of stream, a sweep over all 2^20
// table entries clears the table; requests wait during that sweep
`include "lzw_encoder_12bit_defines.svh"

module lzw_encoder_12bit #(
   parameter int EPOCH_BITS = lzw_pkg::EPOCH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lzw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lzw_pkg::rsp_type rsp_data
);

   localparam int CB = lzw_pkg::CODE_BITS;
   localparam int EW = EPOCH_BITS + CB;

   // stage 1: request waiting for its table read
   logic             s1_valid_ff, s1_valid_in;
   lzw_pkg::req_type s1_req_ff;
   // stage 2: table data back, resolve
   logic             s2_valid_ff, s2_valid_in;
   lzw_pkg::req_type s2_req_ff;

   // encoder state kept in flops; the dictionary itself lives in the ram
   logic [CB-1:0] prefix_ff, prefix_in;
   logic          prefix_valid_ff, prefix_valid_in;
   logic [CB-1:0] next_code_ff, next_code_in;

   lzw_pkg::clr_stat_type         clr_stat;
   logic [EPOCH_BITS-1:0]         epoch;
   logic                          eos;

   logic                          rd_issue;
   logic                          s2_fire;
   logic                          req_accept;
   logic                          room;
   logic                          hit;
   logic                          add_pair;
   logic [lzw_pkg::IDX_BITS-1:0]  rd_addr;
   logic [lzw_pkg::IDX_BITS-1:0]  s2_idx;
   logic [EW-1:0]                 rd_data;
   logic                          wr_en;
   logic [lzw_pkg::IDX_BITS-1:0]  wr_addr;
   logic [EW-1:0]                 wr_data;
   lzw_pkg::push_type             push;

   // interlock: a read waits until the request ahead has settled the prefix
   assign rd_issue   = s1_valid_ff && !s2_valid_ff && !clr_stat.busy;
   assign req_ready  = !clr_stat.busy && (!s1_valid_ff || rd_issue);
   assign req_accept = req_valid && req_ready;
   assign s2_fire    = s2_valid_ff && room;

   assign rd_addr = {prefix_ff, s1_req_ff.byte_value};
   assign s2_idx  = {prefix_ff, s2_req_ff.byte_value};

   // an entry counts only if written in this stream's epoch
   assign hit = (rd_data[CB-1:0] != '0) && (rd_data[EW-1:CB] == epoch);

   assign add_pair = s2_fire && (s2_req_ff.kind == lzw_pkg::KIND_DATA) && prefix_valid_ff
                     && !hit && (next_code_ff < lzw_pkg::END_CODE);
   assign eos      = s2_fire && (s2_req_ff.kind == lzw_pkg::KIND_END);

   // the sweep owns the write port while it runs
   assign wr_en   = clr_stat.busy || add_pair;
   assign wr_addr = clr_stat.busy ? clr_stat.addr : s2_idx;
   assign wr_data = clr_stat.busy ? '0 : {epoch, next_code_ff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (rd_issue) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (rd_issue) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end
   end

   // resolve one request: prefix update and codes to emit
   always_comb begin
      prefix_in       = prefix_ff;
      prefix_valid_in = prefix_valid_ff;
      next_code_in    = next_code_ff;
      push.n          = 2'd0;
      push.ent0.code  = prefix_ff;
      push.ent0.last  = 1'b0;
      push.ent1.code  = lzw_pkg::END_CODE;
      push.ent1.last  = 1'b1;
      if (s2_fire) begin
         if (s2_req_ff.kind == lzw_pkg::KIND_END) begin
            // flush pending prefix, then end code; back to stream start
            if (prefix_valid_ff) begin
               push.n = 2'd2;
            end else begin
               push.n         = 2'd1;
               push.ent0.code = lzw_pkg::END_CODE;
               push.ent0.last = 1'b1;
            end
            prefix_in       = '0;
            prefix_valid_in = 1'b0;
            next_code_in    = lzw_pkg::FIRST_FREE;
         end else if (!prefix_valid_ff) begin
            // first byte of a stream
            prefix_in       = {{(CB-lzw_pkg::BYTE_BITS){1'b0}}, s2_req_ff.byte_value};
            prefix_valid_in = 1'b1;
         end else if (hit) begin
            prefix_in = rd_data[CB-1:0];
         end else begin
            push.n    = 2'd1;
            prefix_in = {{(CB-lzw_pkg::BYTE_BITS){1'b0}}, s2_req_ff.byte_value};
            if (add_pair) begin
               next_code_in = next_code_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (rd_issue) begin
         s2_req_ff <= s1_req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         prefix_ff       <= '0;
         prefix_valid_ff <= 1'b0;
         next_code_ff    <= lzw_pkg::FIRST_FREE;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         prefix_ff       <= prefix_in;
         prefix_valid_ff <= prefix_valid_in;
         next_code_ff    <= next_code_in;
      end
   end

   // child table: {epoch mark, child code} per (prefix, byte)
   lzw_ram #(
      .WIDTH (EW),
      .DEPTH (lzw_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzw_clear #(
      .EPOCH_BITS (EPOCH_BITS)
   ) u_clear (
      .clock (clock),
      .reset (reset),
      .eos   (eos),
      .stat  (clr_stat),
      .epoch (epoch)
   );

   lzw_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // table sweep must be running right after reset
   `LZW_ASSERT_IMPL(a_clear_after_reset, $fell(reset), clr_stat.busy)
   // only the end code carries last
   `LZW_ASSERT_IMPL(a_last_is_end, !reset && rsp_valid && rsp_data.last,
                    rsp_data.code == lzw_pkg::END_CODE)
   // free code counter never passes the end code
   `LZW_ASSERT(a_next_code_range, next_code_ff <= lzw_pkg::END_CODE)

endmodule

>>> dv/lzw_encoder_12bit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the 12-bit lzw encoder: directed streams, a dictionary fill
// and random streams, checked code by code against an in-bench encoder model
// depends on lzw_pkg and the lzw_encoder_12bit rtl
module lzw_encoder_12bit_tb;

   localparam int     MAX_IDLE     = 16;
   localparam int     MAX_REPORTS  = 10;
   localparam int     RANDOM_ITEMS = 950;
   // result path runs through the encoder's registers and output queue; allow a full receiver stall on top
   localparam int     DRAIN_CYCLES = 40;
   // table sweep after reset covers all 2^20 table entries; the limit leaves room for the rest
   localparam longint CYCLE_LIMIT  = 4_000_000;
   // a second sweep starts at the 256th end of stream, so stay well below that
   localparam int     END_BUDGET   = 150;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   lzw_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   lzw_pkg::rsp_type rsp_data;

   lzw_encoder_12bit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // encoder model state: child codes per (prefix, byte), zero means no child
   bit   [lzw_pkg::CODE_BITS-1:0] child_codes [lzw_pkg::TABLE_DEPTH];
   int                            filled_slots[$];
   logic [lzw_pkg::CODE_BITS-1:0] prefix_code;
   logic [lzw_pkg::CODE_BITS-1:0] free_code;
   bit                            have_prefix;

   // codes still owed by the block, oldest first
   lzw_pkg::rsp_type pending_codes[$];

   int     mismatch_count;
   int     ends_sent;
   bit     req_idle_en;
   bit     rsp_idle_en;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // back to an empty dictionary; only slots actually written are cleared
   function automatic void clear_dictionary();
      foreach (filled_slots[i]) child_codes[filled_slots[i]] = '0;
      filled_slots.delete();
      free_code   = lzw_pkg::FIRST_FREE;
      prefix_code = '0;
      have_prefix = 1'b0;
   endfunction

   function automatic void owe_code(logic [lzw_pkg::CODE_BITS-1:0] code, logic last);
      lzw_pkg::rsp_type r;
      r.code = code;
      r.last = last;
      pending_codes.push_back(r);
   endfunction

   // one accepted request through the encoder model
   function automatic void encode_step(lzw_pkg::req_type item);
      logic [lzw_pkg::IDX_BITS-1:0]  slot;
      logic [lzw_pkg::CODE_BITS-1:0] child;
      if (item.kind == lzw_pkg::KIND_END) begin
         // flush pending prefix, then the end code
         if (have_prefix) owe_code(prefix_code, 1'b0);
         owe_code(lzw_pkg::END_CODE, 1'b1);
         clear_dictionary();
         ends_sent++;
      end else if (!have_prefix) begin
         // first byte of a stream only becomes the prefix
         prefix_code = lzw_pkg::CODE_BITS'(item.byte_value);
         have_prefix = 1'b1;
      end else begin
         slot  = {prefix_code, item.byte_value};
         child = child_codes[slot];
         if (child != '0) begin
            prefix_code = child;
         end else begin
            owe_code(prefix_code, 1'b0);
            // no new pair once the dictionary is full
            if (free_code != lzw_pkg::END_CODE) begin
               child_codes[slot] = free_code;
               filled_slots.push_back(int'(slot));
               free_code++;
            end
            prefix_code = lzw_pkg::CODE_BITS'(item.byte_value);
         end
      end
   endfunction

   function automatic void check_code(lzw_pkg::rsp_type got);
      lzw_pkg::rsp_type want;
      if (pending_codes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected code: actual code %0d last %0b", got.code, got.last);
      end else begin
         want = pending_codes.pop_front();
         if (got.code !== want.code || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("code error: expected code %0d last %0b, actual code %0d last %0b",
                        want.code, want.last, got.code, got.last);
         end
      end
   endfunction

   // result side: random stall before each code, then take it
   initial begin : rsp_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_code(rsp_data);
      end
   end

   // one request: optional gap, then hold valid until taken
   // valid is only dropped when a gap follows, so back-to-back requests keep it high
   task automatic send_req(lzw_pkg::req_type item);
      int gap;
      gap = req_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      encode_step(item);
   endtask

   task automatic send_byte(logic [lzw_pkg::BYTE_BITS-1:0] b);
      lzw_pkg::req_type item;
      item.kind       = lzw_pkg::KIND_DATA;
      item.byte_value = b;
      send_req(item);
   endtask

   // byte field of an end request is don't-care, so it carries noise
   task automatic send_end(logic [lzw_pkg::BYTE_BITS-1:0] b);
      lzw_pkg::req_type item;
      item.kind       = lzw_pkg::KIND_END;
      item.byte_value = b;
      send_req(item);
   endtask

   // sender goes quiet until every owed code has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_codes.size() != 0);
   endtask

   // two empty streams, two ends in a row: only the end code each time
   task automatic test_empty_streams();
      send_end(8'h00);
      send_end(8'hFF);
   endtask

   // single byte streams at both byte extremes
   task automatic test_single_bytes();
      send_byte(8'h00);
      send_end(8'h00);
      send_byte(8'hFF);
      send_end(8'hFF);
   endtask

   // alternating extremes build and hit two-byte strings, a run builds longer ones
   task automatic test_repeated_patterns();
      for (int i = 0; i < 7; i++) send_byte((i % 2) ? 8'hFF : 8'h00);
      send_end(8'h5A);
      repeat (6) send_byte(8'hFF);
      send_end(8'h00);
   endtask

   // end request with a nonzero byte field
   task automatic test_end_ignores_byte();
      send_byte(8'h07);
      send_end(8'hA5);
   endtask

   // stall the sender mid-stream until the block has nothing left to send
   task automatic test_pause_drain();
      for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 3)));
      wait_drained();
      for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 3)));
      send_end(8'($urandom_range(0, 255)));
   endtask

   // one long stream of random bytes until every free code is taken, then keep going
   task automatic test_dictionary_full();
      int guard;
      req_idle_en = 1'b0;
      rsp_idle_en = ($urandom_range(0, 1) != 0);
      guard = 0;
      while (free_code != lzw_pkg::END_CODE && guard < 20000) begin
         send_byte(8'($urandom_range(0, 255)));
         guard++;
      end
      // full dictionary: codes still come out, nothing is added
      repeat (200) send_byte(8'($urandom_range(0, 255)));
      send_end(8'($urandom_range(0, 255)));
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // random streams: mostly well formed with small alphabets for deep strings,
   // some full-range content, some empty streams and early ends
   task automatic test_random_streams();
      int                            sent;
      int                            len;
      int                            span;
      logic [lzw_pkg::BYTE_BITS-1:0] base;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // idling per stream; each side runs flat out in about a quarter of streams
         req_idle_en = ($urandom_range(0, 3) != 0);
         rsp_idle_en = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 15) == 0 && ends_sent < END_BUDGET) begin
            send_end(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            if (ends_sent >= END_BUDGET + 50)
               len = 200;
            else if ($urandom_range(0, 7) == 0)
               len = $urandom_range(60, 150);
            else
               len = $urandom_range(2, 40);
            span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 8);
            base = 8'($urandom_range(0, 255));
            for (int i = 0; i < len; i++) begin
               // rare broken stream: end lands in the middle
               if ($urandom_range(0, 63) == 0 && ends_sent < END_BUDGET) begin
                  send_end(8'($urandom_range(0, 255)));
                  sent++;
               end
               send_byte(base + 8'($urandom_range(0, span - 1)));
               sent++;
            end
            send_end(8'($urandom_range(0, 255)));
            sent++;
         end
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin : main
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      mismatch_count = 0;
      ends_sent      = 0;
      req_idle_en    = 1'b1;
      rsp_idle_en    = 1'b1;
      clear_dictionary();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first request sits through the post-reset table sweep
      test_empty_streams();
      test_single_bytes();
      test_repeated_patterns();
      test_end_ignores_byte();
      test_pause_drain();
      test_dictionary_full();
      test_random_streams();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_codes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
